// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, register indexes and reset values of the periodic task
// scheduler with its sleep power machine.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int TICKS_W     = 20;
    localparam int PERIOD_W    = 16;
    localparam int TIME_W      = 32;
    localparam int DIVIDEND_W  = TIME_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MASK_W      = 4;
    localparam int MAX_TASKS   = 4;
    localparam int MODE_W      = 2;

    localparam int TASK_COUNT_DEF = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_MS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ANIMATION_PERIOD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STATUS_PERIOD    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_ENABLE     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TIMEOUT    = 3'd6;

    // Reset values
    localparam logic [TICKS_W-1:0]  TICKS_PER_MS_RST     = 20'd24000;
    localparam logic [PERIOD_W-1:0] BUTTON_PERIOD_RST    = 16'd10;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST    = 16'd100;
    localparam logic [PERIOD_W-1:0] ANIMATION_PERIOD_RST = 16'd50;
    localparam logic [PERIOD_W-1:0] STATUS_PERIOD_RST    = 16'd500;
    localparam logic [TIME_W-1:0]   SLEEP_TIMEOUT_RST    = 32'd60000;

endpackage

// ===== src/pts_div.sv =====
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider, one quotient bit per cycle. Splits the tick sum into
// whole milliseconds and a tick remainder.
// ----------------------------------------------------------------------------
module pts_div
    import pts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TICKS_W-1:0]    divisor,
    output logic                  done,
    output logic [TIME_W-1:0]     quotient,
    output logic [TICKS_W-1:0]    remainder
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [TICKS_W-1:0]    rem_reg;
    logic [TICKS_W-1:0]    div_reg;

    logic [TICKS_W:0]      partial;
    logic [TICKS_W+1:0]    trial;
    logic                  borrow;

    // Bring down the next dividend bit and try the subtraction
    assign partial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign trial   = {1'b0, partial} - {2'b00, div_reg};
    assign borrow  = trial[TICKS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                num_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[DIVIDEND_W-2:0], ~borrow};
                if (!borrow)
                begin
                    rem_reg <= trial[TICKS_W-1:0];
                end
                else
                begin
                    rem_reg <= partial[TICKS_W-1:0];
                end
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg[TIME_W-1:0];
    assign remainder = rem_reg;

endmodule

// ===== src/periodic_task_scheduler_with_sleep.sv =====
// ----------------------------------------------------------------------------
// periodic_task_scheduler_with_sleep
// Millisecond clock, periodic task due checks and a sleep power machine,
// one main-loop pass per transfer.
// ----------------------------------------------------------------------------
// One pass at a time: a new transfer is stalled until the result is loaded; the
// pass runs through the 33-step bit-serial divider and the shared subtract-compare
// unit, used once per task and once for the sleep timeout.
// Reset: asynchronous, active low; registers take their reset values and the
// millisecond clock, tick remainder and task run times clear at once.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_with_sleep
    import pts_pkg::*;
#(
    parameter int TASK_COUNT = TASK_COUNT_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [TIME_W-1:0]      pass_ticks,
    input  logic                   activity,
    input  logic                   sleep_request,
    input  logic                   wake,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [MASK_W-1:0]      due_mask,
    output logic [TIME_W-1:0]      time_ms,
    output logic [MODE_W-1:0]      power_mode,
    output logic                   display_enable,
    output logic                   converter_enable,
    output logic                   button_irq_mode
);

    localparam int TASKS_USED = (TASK_COUNT < MAX_TASKS) ? TASK_COUNT : MAX_TASKS;
    localparam int IDX_W      = (TASKS_USED > 1) ? $clog2(TASKS_USED) : 1;
    localparam logic [IDX_W-1:0] LAST_TASK = IDX_W'(TASKS_USED - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_TASK,
        S_POWER,
        S_OUT
    } state_t;

    typedef enum logic [MODE_W-1:0] {
        PH_ACTIVE   = 2'd0,
        PH_PREPARE  = 2'd1,
        PH_SLEEPING = 2'd2,
        PH_RESTORE  = 2'd3
    } phase_t;

    // Configuration
    logic [TICKS_W-1:0]  ticks_per_ms_reg;
    logic [PERIOD_W-1:0] period_reg [MAX_TASKS];
    logic                sleep_enable_reg;
    logic [TIME_W-1:0]   sleep_timeout_reg;

    // Scheduler state
    state_t              state_reg;
    phase_t              phase_reg;
    logic [TICKS_W-1:0]  tick_rem_reg;
    logic [TIME_W-1:0]   ms_clock_reg;
    logic [TIME_W-1:0]   last_run_reg [TASKS_USED];
    logic [TIME_W-1:0]   activity_time_reg;
    logic                sleep_pending_reg;
    logic                disp_en_reg;
    logic                conv_en_reg;
    logic                irq_mode_reg;

    // Pass in progress
    logic                activity_reg;
    logic                sleep_req_reg;
    logic                wake_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MASK_W-1:0]   due_reg;

    // Result register
    logic                result_valid_reg;
    logic [MASK_W-1:0]   due_mask_reg;
    logic [TIME_W-1:0]   time_ms_reg;
    logic [MODE_W-1:0]   power_mode_reg;
    logic                display_enable_reg;
    logic                converter_enable_reg;
    logic                button_irq_mode_reg;

    logic                  item_xfer;
    logic                  out_free;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [TICKS_W-1:0]    div_divisor;
    logic                  div_done;
    logic [TIME_W-1:0]     div_quotient;
    logic [TICKS_W-1:0]    div_remainder;
    logic [TIME_W-1:0]     ms_sum;

    logic [TIME_W-1:0]     cmp_a;
    logic [TIME_W-1:0]     cmp_b;
    logic [TIME_W-1:0]     cmp_c;
    logic [TIME_W-1:0]     cmp_diff;
    logic                  cmp_ge;

    assign item_stall = (state_reg != S_IDLE);
    assign item_xfer  = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    assign div_dividend = {1'b0, pass_ticks}
                        + {{(DIVIDEND_W - TICKS_W){1'b0}}, tick_rem_reg};
    // A zero setting divides by one
    assign div_divisor  = (ticks_per_ms_reg == '0) ? TICKS_W'(1) : ticks_per_ms_reg;

    pts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (item_xfer),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign ms_sum = ms_clock_reg + div_quotient;

    // Shared wrap-around elapsed-time compare: (a - b) mod 2^32 >= c
    always_comb
    begin
        cmp_a = ms_clock_reg;
        cmp_b = activity_time_reg;
        cmp_c = sleep_timeout_reg;
        if (state_reg == S_TASK)
        begin
            cmp_b = last_run_reg[idx_reg];
            cmp_c = {{(TIME_W - PERIOD_W){1'b0}}, period_reg[idx_reg]};
        end
    end

    assign cmp_diff = cmp_a - cmp_b;
    assign cmp_ge   = (cmp_diff >= cmp_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_ms_reg     <= TICKS_PER_MS_RST;
            period_reg[0]        <= BUTTON_PERIOD_RST;
            period_reg[1]        <= SAMPLE_PERIOD_RST;
            period_reg[2]        <= ANIMATION_PERIOD_RST;
            period_reg[3]        <= STATUS_PERIOD_RST;
            sleep_enable_reg     <= 1'b0;
            sleep_timeout_reg    <= SLEEP_TIMEOUT_RST;
            state_reg            <= S_IDLE;
            phase_reg            <= PH_ACTIVE;
            tick_rem_reg         <= '0;
            ms_clock_reg         <= '0;
            for (int i = 0; i < TASKS_USED; i++)
            begin
                last_run_reg[i] <= '0;
            end
            activity_time_reg    <= '0;
            sleep_pending_reg    <= 1'b0;
            disp_en_reg          <= 1'b1;
            conv_en_reg          <= 1'b1;
            irq_mode_reg         <= 1'b0;
            activity_reg         <= 1'b0;
            sleep_req_reg        <= 1'b0;
            wake_reg             <= 1'b0;
            idx_reg              <= '0;
            due_reg              <= '0;
            result_valid_reg     <= 1'b0;
            due_mask_reg         <= '0;
            time_ms_reg          <= '0;
            power_mode_reg       <= '0;
            display_enable_reg   <= 1'b0;
            converter_enable_reg <= 1'b0;
            button_irq_mode_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TICKS_PER_MS:     ticks_per_ms_reg  <= cfg_data[TICKS_W-1:0];
                    REG_BUTTON_PERIOD:    period_reg[0]     <= cfg_data[PERIOD_W-1:0];
                    REG_SAMPLE_PERIOD:    period_reg[1]     <= cfg_data[PERIOD_W-1:0];
                    REG_ANIMATION_PERIOD: period_reg[2]     <= cfg_data[PERIOD_W-1:0];
                    REG_STATUS_PERIOD:    period_reg[3]     <= cfg_data[PERIOD_W-1:0];
                    REG_SLEEP_ENABLE:     sleep_enable_reg  <= cfg_data[0];
                    REG_SLEEP_TIMEOUT:    sleep_timeout_reg <= cfg_data[TIME_W-1:0];
                    default:              ;
                endcase
            end

            // Drop the result once it has been transferred; S_OUT reloads it itself
            if (result_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_xfer)
                    begin
                        activity_reg  <= activity;
                        sleep_req_reg <= sleep_request;
                        wake_reg      <= wake;
                        state_reg     <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        ms_clock_reg <= ms_sum;
                        tick_rem_reg <= div_remainder;
                        if (activity_reg)
                        begin
                            activity_time_reg <= ms_sum;
                        end
                        if (sleep_req_reg)
                        begin
                            sleep_pending_reg <= 1'b1;
                        end
                        idx_reg   <= '0;
                        due_reg   <= '0;
                        state_reg <= S_TASK;
                    end
                end

                S_TASK:
                begin
                    if (cmp_ge)
                    begin
                        last_run_reg[idx_reg] <= ms_clock_reg;
                        due_reg[idx_reg]      <= 1'b1;
                    end
                    if (idx_reg == LAST_TASK)
                    begin
                        state_reg <= S_POWER;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                S_POWER:
                begin
                    case (phase_reg)
                        PH_ACTIVE:
                        begin
                            if (sleep_pending_reg || (sleep_enable_reg && cmp_ge))
                            begin
                                phase_reg <= PH_PREPARE;
                            end
                        end
                        PH_PREPARE:
                        begin
                            disp_en_reg  <= 1'b0;
                            conv_en_reg  <= 1'b0;
                            irq_mode_reg <= 1'b1;
                            phase_reg    <= PH_SLEEPING;
                        end
                        PH_SLEEPING:
                        begin
                            if (wake_reg)
                            begin
                                phase_reg <= PH_RESTORE;
                            end
                        end
                        default:
                        begin
                            disp_en_reg       <= 1'b1;
                            conv_en_reg       <= 1'b1;
                            irq_mode_reg      <= 1'b0;
                            sleep_pending_reg <= 1'b0;
                            tick_rem_reg      <= '0;
                            activity_time_reg <= ms_clock_reg;
                            phase_reg         <= PH_ACTIVE;
                        end
                    endcase
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        result_valid_reg     <= 1'b1;
                        due_mask_reg         <= due_reg;
                        time_ms_reg          <= ms_clock_reg;
                        power_mode_reg       <= phase_reg;
                        display_enable_reg   <= disp_en_reg;
                        converter_enable_reg <= conv_en_reg;
                        button_irq_mode_reg  <= irq_mode_reg;
                        state_reg            <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid     = result_valid_reg;
    assign due_mask         = due_mask_reg;
    assign time_ms          = time_ms_reg;
    assign power_mode       = power_mode_reg;
    assign display_enable   = display_enable_reg;
    assign converter_enable = converter_enable_reg;
    assign button_irq_mode  = button_irq_mode_reg;

    a_xfer_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> (state_reg == S_DIV))
        else $error("transfer did not start a division");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the division phase");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TASK && $past(state_reg) == S_DIV) |-> (tick_rem_reg < div_divisor))
        else $error("tick remainder not below ticks per millisecond");

    a_phase_steps_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_POWER) |=> $stable(phase_reg))
        else $error("power phase moved outside its step");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && result_valid_reg && result_stall) |=> (state_reg == S_OUT))
        else $error("result overwritten while stalled");

endmodule
